// ===== rtl/core/lcdns_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types, command codes and constant tables for the character LCD nibble
// sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

    localparam int COLUMNS      = 20;
    localparam int QUEUE_DEPTH  = 4;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [APB_AW-1:0] REG_DISPLAY_ENABLE = 3'h0;

    localparam logic [2:0] CMD_INSTR = 3'd0;
    localparam logic [2:0] CMD_DATA  = 3'd1;
    localparam logic [2:0] CMD_LOC   = 3'd2;
    localparam logic [2:0] CMD_INIT  = 3'd3;
    localparam logic [2:0] CMD_GLYPH = 3'd4;
    localparam logic [2:0] CMD_CLEAR = 3'd5;

    localparam logic [15:0] GAP_US        = 16'd40;
    localparam logic [10:0] HOLD_CLEAR_US = 11'd2000;
    localparam logic [7:0]  CLEAR_BYTE    = 8'h01;

    localparam logic [4:0] INIT_LAST_STEP  = 5'd13;
    localparam logic [4:0] GLYPH_LAST_STEP = 5'd17;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] byte_value;
        logic [4:0] column;
        logic [1:0] row;
        logic [2:0] glyph_index;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        reg_select;
        logic [15:0] wait_before_us;
        logic [10:0] wait_after_us;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_CLEAR,
        KIND_INIT,
        KIND_GLYPH
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       rs;
        logic [7:0] data;
        logic [2:0] slot;
    } t_desc;

    typedef struct packed {
        logic [3:0]  nibble;
        logic [15:0] wait_us;
    } t_init_ent;

    localparam logic [7:0] GLYPH_ROWS [0:7][0:7] = '{
        '{8'h17, 8'h15, 8'h15, 8'h15, 8'h15, 8'h15, 8'h17, 8'h00},
        '{8'h12, 8'h12, 8'h12, 8'h12, 8'h12, 8'h12, 8'h12, 8'h00},
        '{8'h17, 8'h11, 8'h11, 8'h17, 8'h14, 8'h14, 8'h17, 8'h00},
        '{8'h17, 8'h11, 8'h11, 8'h17, 8'h11, 8'h11, 8'h17, 8'h00},
        '{8'h15, 8'h15, 8'h15, 8'h17, 8'h11, 8'h11, 8'h11, 8'h00},
        '{8'h17, 8'h14, 8'h14, 8'h17, 8'h11, 8'h11, 8'h17, 8'h00},
        '{8'h17, 8'h14, 8'h14, 8'h17, 8'h15, 8'h15, 8'h17, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] base;
        begin
            unique case (row)
                2'd0:    base = 7'h00;
                2'd1:    base = 7'h40;
                2'd2:    base = 7'h14;
                default: base = 7'h54;
            endcase
            return base;
        end
    endfunction

    function automatic t_init_ent init_strobe(input logic [3:0] step);
        t_init_ent e;
        begin
            unique case (step)
                4'd0:    e = '{nibble: 4'h3, wait_us: 16'd40000};
                4'd1:    e = '{nibble: 4'h3, wait_us: 16'd4100};
                4'd2:    e = '{nibble: 4'h3, wait_us: 16'd100};
                4'd3:    e = '{nibble: 4'h2, wait_us: 16'd40};
                4'd4:    e = '{nibble: 4'h2, wait_us: 16'd2000};
                4'd5:    e = '{nibble: 4'h8, wait_us: 16'd0};
                4'd6:    e = '{nibble: 4'h0, wait_us: 16'd40};
                4'd7:    e = '{nibble: 4'h8, wait_us: 16'd0};
                4'd8:    e = '{nibble: 4'h0, wait_us: 16'd40};
                4'd9:    e = '{nibble: 4'h1, wait_us: 16'd0};
                4'd10:   e = '{nibble: 4'h0, wait_us: 16'd2000};
                4'd11:   e = '{nibble: 4'h6, wait_us: 16'd0};
                4'd12:   e = '{nibble: 4'h0, wait_us: 16'd40};
                4'd13:   e = '{nibble: 4'hC, wait_us: 16'd0};
                default: e = '{nibble: 4'h0, wait_us: 16'd0};
            endcase
            return e;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lcdns_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_front
// Accepts commands, drops those that give no strobes and turns the rest
// into a compact job descriptor for the queue.
// ----------------------------------------------------------------------------
module lcdns_front (
    input  wire                 i_display_enable,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  lcdns_pkg::t_in_item i_in,
    input  wire                 i_full,
    output logic                o_push,
    output lcdns_pkg::t_desc    o_desc
);

    logic        known;
    logic [4:0]  col_sat;
    logic [7:0]  addr_sum;

    assign o_in_stall = i_full;

    always_comb begin
        col_sat = ({1'b0, i_in.column} >= 6'(lcdns_pkg::COLUMNS))
                ? 5'(lcdns_pkg::COLUMNS - 1) : i_in.column;
        addr_sum = {1'b0, lcdns_pkg::row_base(i_in.row)} + {3'b0, col_sat};

        known       = 1'b1;
        o_desc.kind = lcdns_pkg::KIND_BYTE;
        o_desc.rs   = 1'b0;
        o_desc.data = i_in.byte_value;
        o_desc.slot = i_in.glyph_index;
        unique case (i_in.cmd)
            lcdns_pkg::CMD_INSTR: ;
            lcdns_pkg::CMD_DATA: begin
                o_desc.rs = 1'b1;
            end
            lcdns_pkg::CMD_LOC: begin
                o_desc.data = {1'b1, addr_sum[6:0]};
            end
            lcdns_pkg::CMD_INIT: begin
                o_desc.kind = lcdns_pkg::KIND_INIT;
            end
            lcdns_pkg::CMD_GLYPH: begin
                o_desc.kind = lcdns_pkg::KIND_GLYPH;
            end
            lcdns_pkg::CMD_CLEAR: begin
                o_desc.kind = lcdns_pkg::KIND_CLEAR;
                o_desc.data = lcdns_pkg::CLEAR_BYTE;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign o_push = i_in_valid && !i_full && i_display_enable && known;

endmodule
`default_nettype wire

// ===== rtl/core/lcdns_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_queue
// Short show-ahead queue of job descriptors between front and back.
// ----------------------------------------------------------------------------
module lcdns_queue #(
    parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  lcdns_pkg::t_desc i_push_data,
    output logic             o_full,
    output logic             o_head_valid,
    output lcdns_pkg::t_desc o_head,
    input  wire              i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lcdns_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/lcdns_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_back
// Steps through the job at the queue head, one strobe per beat, into a
// registered output stage.
// ----------------------------------------------------------------------------
module lcdns_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_head_valid,
    input  lcdns_pkg::t_desc     i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output lcdns_pkg::t_out_item o_out,
    input  wire                  i_out_stall
);

    logic [4:0]           r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    lcdns_pkg::t_out_item r_out;
    lcdns_pkg::t_out_item strobe;
    lcdns_pkg::t_init_ent init_ent;
    logic [7:0]           cur_byte;
    logic [4:0]           row_off;
    logic                 load;

    assign init_ent = lcdns_pkg::init_strobe(r_step[3:0]);
    assign row_off  = r_step - 5'd2;

    always_comb begin
        strobe   = '0;
        cur_byte = i_head.data;
        unique case (i_head.kind) inside
            lcdns_pkg::KIND_BYTE, lcdns_pkg::KIND_CLEAR: begin
                strobe.nibble         = r_step[0] ? cur_byte[3:0] : cur_byte[7:4];
                strobe.reg_select     = i_head.rs;
                strobe.wait_before_us = r_step[0] ? 16'd0 : lcdns_pkg::GAP_US;
                strobe.wait_after_us  = (r_step[0] && i_head.kind == lcdns_pkg::KIND_CLEAR)
                                      ? lcdns_pkg::HOLD_CLEAR_US : 11'd0;
                strobe.last           = r_step[0];
            end
            lcdns_pkg::KIND_INIT: begin
                strobe.nibble         = init_ent.nibble;
                strobe.wait_before_us = init_ent.wait_us;
                strobe.last           = (r_step == lcdns_pkg::INIT_LAST_STEP);
            end
            default: begin
                if (r_step < 5'd2) begin
                    cur_byte = {2'b01, i_head.slot, 3'b000};
                end else begin
                    cur_byte = lcdns_pkg::GLYPH_ROWS[i_head.slot][row_off[3:1]];
                    strobe.reg_select     = 1'b1;
                    strobe.wait_before_us = r_step[0] ? 16'd0 : lcdns_pkg::GAP_US;
                end
                strobe.nibble = r_step[0] ? cur_byte[3:0] : cur_byte[7:4];
                strobe.last   = (r_step == lcdns_pkg::GLYPH_LAST_STEP);
            end
        endcase
    end

    assign load  = i_head_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = load && strobe.last;

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        if (load) begin
            n_out_valid = 1'b1;
            n_step      = strobe.last ? 5'd0 : r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= strobe;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= lcdns_pkg::GLYPH_LAST_STEP)
        else $error("strobe step out of range");

    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> r_step == 5'd0)
        else $error("step counter not at start with queue empty");

    a_pop_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_step == 5'd0 && r_out_valid && o_out.last)
        else $error("job retired without its last strobe");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/char_lcd_nibble_sequencer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Expands LCD commands into 4-bit bus strobes with register select and waits.
// ----------------------------------------------------------------------------
// The first strobe of a command passes through the descriptor queue and then
// the registered output stage.
// Throughput: one strobe per cycle while the sink does not stall; a command steps
// the strobe stepper through 2 strobes (byte, locate, clear), 14 (init) or 18 (load glyph).
// Input is stalled only while the descriptor queue is full.
// Reset: queue and output stage empty, display_enable set to 1.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core #(
    parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [lcdns_pkg::APB_AW-1:0]     paddr,
    input  wire  [lcdns_pkg::APB_DW-1:0]     pwdata,
    output logic [lcdns_pkg::APB_DW-1:0]     prdata,
    output logic                             pready,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  lcdns_pkg::t_in_item              i_in,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output lcdns_pkg::t_out_item             o_out
);

    logic             r_display_enable;
    logic             reg_hit;
    logic             push;
    logic             pop;
    logic             full;
    logic             head_valid;
    lcdns_pkg::t_desc desc;
    lcdns_pkg::t_desc head;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[lcdns_pkg::APB_AW-1:2]
                      == lcdns_pkg::REG_DISPLAY_ENABLE[lcdns_pkg::APB_AW-1:2]);
    assign prdata  = reg_hit ? {{(lcdns_pkg::APB_DW-1){1'b0}}, r_display_enable} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enable <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_display_enable <= pwdata[0];
        end
    end

    lcdns_front u_front (
        .i_display_enable (r_display_enable),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in             (i_in),
        .i_full           (full),
        .o_push           (push),
        .o_desc           (desc)
    );

    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (desc),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    lcdns_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_stall  (i_out_stall)
    );

endmodule
`default_nettype wire

// ===== bench/char_lcd_nibble_sequencer_core_tb.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core testbench
// Sends LCD commands (byte, locate, init, glyph load, clear, spare codes)
// through the valid/stall input port, predicts every 4-bit strobe in the
// bench, and checks each output beat in order, field by field. The display
// enable register is programmed and read back over APB between phases.
// Random phases vary source idling and sink stall, with one long sink
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdns_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [APB_AW-1:0] REG_UNMAPPED = 3'h4;

    localparam logic [7:0]  SET_CGRAM    = 8'h40;
    localparam logic [7:0]  SET_DDRAM    = 8'h80;
    localparam logic [15:0] NO_WAIT      = 16'd0;
    localparam logic [10:0] NO_HOLD      = 11'd0;
    localparam int          SETTLE_CYCLES = (QUEUE_DEPTH + 2) * 18;
    localparam int          CYCLE_LIMIT   = 1000000;

    localparam logic [6:0]  ROW_ADDR [0:3] = '{7'h00, 7'h40, 7'h14, 7'h54};
    localparam logic [3:0]  WAKE_NIBBLE [0:3] = '{4'h3, 4'h3, 4'h3, 4'h2};
    localparam logic [15:0] WAKE_WAIT [0:3] = '{16'd40000, 16'd4100, 16'd100, 16'd40};
    localparam logic [7:0]  SETUP_BYTE [0:4] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
    localparam logic [15:0] SETUP_WAIT [0:4] =
        '{16'd2000, 16'd40, 16'd40, 16'd2000, 16'd40};

    localparam logic [7:0] GLYPH_BITMAP [0:7][0:7] = '{
        '{8'h17, 8'h15, 8'h15, 8'h15, 8'h15, 8'h15, 8'h17, 8'h00},
        '{8'h12, 8'h12, 8'h12, 8'h12, 8'h12, 8'h12, 8'h12, 8'h00},
        '{8'h17, 8'h11, 8'h11, 8'h17, 8'h14, 8'h14, 8'h17, 8'h00},
        '{8'h17, 8'h11, 8'h11, 8'h17, 8'h11, 8'h11, 8'h17, 8'h00},
        '{8'h15, 8'h15, 8'h15, 8'h17, 8'h11, 8'h11, 8'h11, 8'h00},
        '{8'h17, 8'h14, 8'h14, 8'h17, 8'h11, 8'h11, 8'h17, 8'h00},
        '{8'h17, 8'h14, 8'h14, 8'h17, 8'h15, 8'h15, 8'h17, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in        = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out;

    t_out_item pending_strobes[$];
    logic      display_on = 1'b1;
    int        send_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        hold_request = 0;
    int        hold_left = 0;
    int        errors = 0;
    int        commands_sent = 0;
    int        strobes_seen = 0;
    int        cycle_count = 0;

    char_lcd_nibble_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("char_lcd_nibble_sequencer_core: mismatch");
        $finish;
    end

    // ---- strobe predictor ----
    function automatic void put_strobe(logic [3:0] nib, logic rs, logic [15:0] wait_us,
                                       logic [10:0] after, logic is_last);
        t_out_item s;
        s.nibble         = nib;
        s.reg_select     = rs;
        s.wait_before_us = wait_us;
        s.wait_after_us  = after;
        s.last           = is_last;
        pending_strobes.push_back(s);
    endfunction

    function automatic void put_byte(logic [7:0] value, logic rs, logic [15:0] wait_us,
                                     logic is_last);
        put_strobe(value[7:4], rs, wait_us, NO_HOLD, 1'b0);
        put_strobe(value[3:0], rs, NO_WAIT, NO_HOLD, is_last);
    endfunction

    function automatic void expand_command(t_in_item c);
        logic [6:0] col;
        logic [6:0] addr;
        if (!display_on)
            return;
        case (c.cmd)
            CMD_INSTR: put_byte(c.byte_value, 1'b0, GAP_US, 1'b1);
            CMD_DATA:  put_byte(c.byte_value, 1'b1, GAP_US, 1'b1);
            CMD_LOC: begin
                col  = (c.column >= COLUMNS) ? 7'(COLUMNS - 1) : {2'b00, c.column};
                addr = ROW_ADDR[c.row] + col;
                put_byte(SET_DDRAM | {1'b0, addr}, 1'b0, GAP_US, 1'b1);
            end
            CMD_INIT: begin
                for (int i = 0; i < 4; i++)
                    put_strobe(WAKE_NIBBLE[i], 1'b0, WAKE_WAIT[i], NO_HOLD, 1'b0);
                for (int i = 0; i < 5; i++)
                    put_byte(SETUP_BYTE[i], 1'b0, SETUP_WAIT[i], i == 4);
            end
            CMD_GLYPH: begin
                put_byte(SET_CGRAM | {2'b00, c.glyph_index, 3'b000}, 1'b0, NO_WAIT, 1'b0);
                for (int i = 0; i < 8; i++)
                    put_byte(GLYPH_BITMAP[c.glyph_index][i], 1'b1, GAP_US, i == 7);
            end
            CMD_CLEAR: begin
                put_strobe(CLEAR_BYTE[7:4], 1'b0, GAP_US, NO_HOLD, 1'b0);
                put_strobe(CLEAR_BYTE[3:0], 1'b0, NO_WAIT, HOLD_CLEAR_US, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // ---- sink: random stall, or a counted hold-off on request ----
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // ---- output checker ----
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            strobes_seen++;
            if (pending_strobes.size() == 0) begin
                $error("unexpected strobe: nibble %0h rs %0b", o_out.nibble, o_out.reg_select);
                errors++;
            end else begin
                want = pending_strobes.pop_front();
                if (o_out.nibble !== want.nibble) begin
                    $error("nibble: expected %0h, got %0h", want.nibble, o_out.nibble);
                    errors++;
                end
                if (o_out.reg_select !== want.reg_select) begin
                    $error("reg_select: expected %0b, got %0b",
                           want.reg_select, o_out.reg_select);
                    errors++;
                end
                if (o_out.wait_before_us !== want.wait_before_us) begin
                    $error("wait_before_us: expected %0d, got %0d",
                           want.wait_before_us, o_out.wait_before_us);
                    errors++;
                end
                if (o_out.wait_after_us !== want.wait_after_us) begin
                    $error("wait_after_us: expected %0d, got %0d",
                           want.wait_after_us, o_out.wait_after_us);
                    errors++;
                end
                if (o_out.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_out.last);
                    errors++;
                end
            end
        end
    end

    // ---- shared drivers ----
    task automatic issue_command(t_in_item c);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in       <= c;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expand_command(c);
        commands_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_strobes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write one register, then read back display_enable
    task automatic program_display(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == REG_DISPLAY_ENABLE)
            display_on = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_DISPLAY_ENABLE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[0] !== display_on) begin
            $error("display_enable readback: expected %0b, got %0b", display_on, prdata[0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_in_item random_command();
        t_in_item c;
        c.cmd         = ($urandom_range(99) < 90) ? 3'($urandom_range(5)) : 3'($urandom);
        c.byte_value  = 8'($urandom);
        c.column      = 5'($urandom);
        c.row         = 2'($urandom);
        c.glyph_index = 3'($urandom);
        return c;
    endfunction

    function automatic t_in_item make_command(logic [2:0] cmd, logic [7:0] value,
                                              logic [4:0] col, logic [1:0] row,
                                              logic [2:0] slot);
        t_in_item c;
        c.cmd         = cmd;
        c.byte_value  = value;
        c.column      = col;
        c.row         = row;
        c.glyph_index = slot;
        return c;
    endfunction

    // ---- tests ----
    task automatic test_directed();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        issue_command(make_command(CMD_INSTR, 8'h00, 5'd0, 2'd0, 3'd0));
        issue_command(make_command(CMD_INSTR, 8'hFF, 5'd31, 2'd3, 3'd7));
        issue_command(make_command(CMD_DATA, 8'hA5, 5'd0, 2'd0, 3'd0));
        issue_command(make_command(CMD_DATA, 8'h5A, 5'd0, 2'd0, 3'd0));
        issue_command(make_command(CMD_LOC, 8'h00, 5'd0, 2'd0, 3'd0));
        issue_command(make_command(CMD_LOC, 8'h00, 5'd19, 2'd1, 3'd0));
        issue_command(make_command(CMD_LOC, 8'h00, 5'd20, 2'd2, 3'd0));
        issue_command(make_command(CMD_LOC, 8'h00, 5'd31, 2'd3, 3'd0));
        issue_command(make_command(CMD_INIT, 8'h00, 5'd0, 2'd0, 3'd0));
        for (int s = 0; s < 8; s++)
            issue_command(make_command(CMD_GLYPH, 8'h00, 5'd0, 2'd0, 3'(s)));
        issue_command(make_command(CMD_CLEAR, 8'h00, 5'd0, 2'd0, 3'd0));
        issue_command(make_command(CMD_SPARE_LO, 8'hFF, 5'd31, 2'd3, 3'd7));
        issue_command(make_command(CMD_SPARE_HI, 8'h00, 5'd0, 2'd0, 3'd0));
        issue_command(make_command(CMD_CLEAR, 8'h00, 5'd0, 2'd0, 3'd0));
        wait_drain();
    endtask

    task automatic test_display_enable();
        send_idle_pct  = 15;
        sink_stall_pct = 15;
        // unmapped register: write must not touch the enable
        program_display(REG_UNMAPPED, '0);
        issue_command(make_command(CMD_DATA, 8'h41, 5'd0, 2'd0, 3'd0));
        wait_drain();
        // upper bits set, bit 0 clear: display off
        program_display(REG_DISPLAY_ENABLE, 32'hFFFF_FFFE);
        for (int k = 0; k < 8; k++)
            issue_command(make_command(3'(k), 8'($urandom), 5'($urandom), 2'($urandom),
                                       3'($urandom)));
        wait_drain();
        program_display(REG_DISPLAY_ENABLE, 32'h0000_0001);
        issue_command(make_command(CMD_INIT, 8'h00, 5'd0, 2'd0, 3'd0));
        wait_drain();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2)
                wait_drain();
            issue_command(random_command());
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        t_in_item c;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_request   = 300;
        for (int k = 0; k < 12; k++) begin
            c     = random_command();
            c.cmd = (k % 3 == 0) ? CMD_INIT : CMD_GLYPH;
            issue_command(c);
        end
        wait_drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_display_enable();
        test_random_phase(0, 0, 50);
        test_random_phase(85, 0, 50);
        test_random_phase(0, 85, 50);
        test_random_phase(15, 15, 50);
        test_backpressure();

        sink_stall_pct = 0;
        repeat (20) @(posedge i_clk);
        $display("covered %0d commands and %0d strobes in %0d cycles: all command codes,",
                 commands_sent, strobes_seen, cycle_count);
        $display("display on/off, source idle and sink stall phases, long sink hold-off");
        if (errors == 0) begin
            $display("char_lcd_nibble_sequencer_core: match");
        end else begin
            $display("char_lcd_nibble_sequencer_core: mismatch");
        end
        $finish;
    end

endmodule
